// ===== rtl/mstg_pkg.sv =====
// ----------------------------------------------------------------------------
// mstg_pkg
// Types and constants shared by the eight-channel stepper tone generator and
// its port checker.
// ----------------------------------------------------------------------------
package mstg_pkg;

  localparam int CHANNELS        = 8;
  localparam int DRIVES          = 4;
  localparam int DISK_FIRST      = 6;
  localparam int PERIOD_BITS_DEF = 20;

  localparam int PERIOD_IN_BITS = 20;
  localparam int VELOCITY_BITS  = 7;
  localparam int SWEEP_BITS     = 8;
  localparam int IDLE_BITS      = 18;
  localparam int PULSE_BITS     = 10;
  localparam int CFG_DATA_BITS  = 18;
  localparam int CFG_INDEX_BITS = 3;
  localparam int PRODUCT_BITS   = VELOCITY_BITS + PULSE_BITS;

  localparam logic [SWEEP_BITS-1:0] SWEEP0_RESET = 8'd160;
  localparam logic [SWEEP_BITS-1:0] SWEEP_RESET  = 8'd80;
  localparam logic [IDLE_BITS-1:0]  IDLE_RESET   = 18'd200000;
  localparam logic [PULSE_BITS-1:0] PULSE_RESET  = 10'd550;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_code_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SWEEP0 = 3'd0,
    CFG_SWEEP1 = 3'd1,
    CFG_SWEEP2 = 3'd2,
    CFG_SWEEP3 = 3'd3,
    CFG_IDLE   = 3'd4,
    CFG_PULSE  = 3'd5
  } cfg_index_t;

  typedef struct packed {
    cmd_code_t                 command;
    logic [2:0]                channel;
    logic [PERIOD_IN_BITS-1:0] note_period;
    logic [VELOCITY_BITS-1:0]  velocity;
  } cmd_t;

  typedef struct packed {
    logic [DRIVES-1:0] step_pins;
    logic [DRIVES-1:0] direction_bits;
    logic [DRIVES-1:0] enable_n_bits;
    logic              transformer_pin;
    logic              buzzer_pin;
    logic [1:0]        disk_pins;
  } res_t;

endpackage

// ===== rtl/multichannel_stepper_tone_generator.sv =====
// ----------------------------------------------------------------------------
// multichannel_stepper_tone_generator
// Eight square-wave channels: four stepper drives, transformer, buzzer and two
// one-shot disk channels, advanced by tick, set and clear commands.
// ----------------------------------------------------------------------------
// The result of a command is written into the result buffer when the command is taken.
// Throughput: one command per cycle while cmd_stall is low; all channels update in parallel registers.
// A two-entry result buffer keeps commands flowing while a result waits; cmd_stall
// rises only when both entries are held.
// Reset (rst, synchronous): channels idle, drive 0 direction high, enables off,
// configuration registers at their defaults, result buffer empty.
module multichannel_stepper_tone_generator
  import mstg_pkg::*;
#(
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  cmd_t                      cmd,
  output logic                      res_valid,
  input  logic                      res_stall,
  output res_t                      res,
  input  logic                      cfg_wen,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int EB = (PERIOD_BITS > IDLE_BITS) ? PERIOD_BITS : IDLE_BITS;
  localparam logic [32:0] PMAX = (33'd1 << PERIOD_BITS) - 33'd1;

  // configuration
  logic [SWEEP_BITS-1:0] sweep [DRIVES];
  logic [IDLE_BITS-1:0]  idle_ticks;
  logic [PULSE_BITS-1:0] pulse_unit;

  // channel state
  logic [EB-1:0]          elapsed          [CHANNELS];
  logic [EB-1:0]          elapsed_next     [CHANNELS];
  logic [PERIOD_BITS-1:0] half_period      [CHANNELS];
  logic [PERIOD_BITS-1:0] half_period_next [CHANNELS];
  logic [CHANNELS-1:0]    phase, phase_next;
  logic [CHANNELS-1:0]    active, active_next;
  logic [SWEEP_BITS-1:0]  step_count      [DRIVES];
  logic [SWEEP_BITS-1:0]  step_count_next [DRIVES];
  logic [DRIVES-1:0]      direction, direction_next;
  logic [DRIVES-1:0]      enable_n, enable_n_next;

  // tick terms
  logic [EB-1:0]       elapsed_inc [CHANNELS];
  logic [CHANNELS-1:0] fire;
  logic [CHANNELS-1:0] idle_off;

  // result buffer
  res_t       slot0, slot1;
  logic [1:0] fill;
  res_t       res_new;
  logic       push, pop;

  logic [PRODUCT_BITS-1:0] pulse_len;

  function automatic logic [PERIOD_BITS-1:0] sat_period(input logic [PERIOD_IN_BITS-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > PMAX) ? PMAX[PERIOD_BITS-1:0] : w[PERIOD_BITS-1:0];
  endfunction

  assign push      = cmd_valid && !cmd_stall;
  assign pop       = res_valid && !res_stall;
  assign cmd_stall = (fill == 2'd2);
  assign res_valid = (fill != 2'd0);
  assign res       = slot0;
  assign pulse_len = PRODUCT_BITS'(cmd.velocity) * PRODUCT_BITS'(pulse_unit);

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      elapsed_inc[i] = (elapsed[i] == {EB{1'b1}}) ? elapsed[i] : elapsed[i] + EB'(1);
      fire[i]        = (phase[i] || (half_period[i] != '0))
                       && (elapsed_inc[i] >= EB'(half_period[i]));
      idle_off[i]    = (half_period[i] == '0) && active[i]
                       && (elapsed_inc[i] >= EB'(idle_ticks));
    end
  end

  always_comb begin
    elapsed_next     = elapsed;
    half_period_next = half_period;
    phase_next       = phase;
    active_next      = active;
    step_count_next  = step_count;
    direction_next   = direction;
    enable_n_next    = enable_n;
    unique case (cmd.command)
      CMD_TICK: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (fire[i]) begin
            phase_next[i]   = !phase[i];
            elapsed_next[i] = '0;
            if (phase[i] && i >= DISK_FIRST) begin
              active_next[i]      = 1'b0;
              half_period_next[i] = '0;
            end
          end else begin
            elapsed_next[i] = elapsed_inc[i];
            if (idle_off[i]) begin
              active_next[i] = 1'b0;
            end
          end
        end
        for (int j = 0; j < DRIVES; j++) begin
          if (fire[j] && phase[j]) begin
            // count the completed step, reverse at the end of the sweep
            if (step_count[j] + SWEEP_BITS'(1) >= sweep[j]) begin
              step_count_next[j] = '0;
              direction_next[j]  = !direction[j];
            end else begin
              step_count_next[j] = step_count[j] + SWEEP_BITS'(1);
            end
          end else if (!fire[j] && idle_off[j]) begin
            enable_n_next[j] = 1'b1;
          end
        end
      end
      CMD_SET: begin
        for (int j = 0; j < DRIVES; j++) begin
          if (cmd.channel == 3'(j)) begin
            half_period_next[j] = (j == 0) ? sat_period(cmd.note_period >> 2)
                                           : sat_period(cmd.note_period >> 1);
            if (!active[j]) begin
              elapsed_next[j]  = '0;
              enable_n_next[j] = 1'b0;
              active_next[j]   = 1'b1;
            end
          end
        end
        for (int i = DRIVES; i < CHANNELS; i++) begin
          if (cmd.channel == 3'(i)) begin
            active_next[i] = 1'b1;
            half_period_next[i] = (i >= DISK_FIRST)
                                  ? sat_period(PERIOD_IN_BITS'(pulse_len))
                                  : sat_period(cmd.note_period >> 1);
          end
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < DISK_FIRST; i++) begin
          if (cmd.channel == 3'(i)) begin
            half_period_next[i] = '0;
            if (i >= DRIVES) begin
              active_next[i] = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_new.step_pins       = phase_next[DRIVES-1:0];
    res_new.direction_bits  = direction_next;
    res_new.enable_n_bits   = enable_n_next;
    res_new.transformer_pin = phase_next[4];
    res_new.buzzer_pin      = phase_next[5];
    res_new.disk_pins       = phase_next[7:6];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep[0]   <= SWEEP0_RESET;
      sweep[1]   <= SWEEP_RESET;
      sweep[2]   <= SWEEP_RESET;
      sweep[3]   <= SWEEP_RESET;
      idle_ticks <= IDLE_RESET;
      pulse_unit <= PULSE_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_SWEEP0: sweep[0]   <= cfg_data[SWEEP_BITS-1:0];
        CFG_SWEEP1: sweep[1]   <= cfg_data[SWEEP_BITS-1:0];
        CFG_SWEEP2: sweep[2]   <= cfg_data[SWEEP_BITS-1:0];
        CFG_SWEEP3: sweep[3]   <= cfg_data[SWEEP_BITS-1:0];
        CFG_IDLE:   idle_ticks <= cfg_data[IDLE_BITS-1:0];
        CFG_PULSE:  pulse_unit <= cfg_data[PULSE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        elapsed[i]     <= '0;
        half_period[i] <= '0;
      end
      for (int j = 0; j < DRIVES; j++) begin
        step_count[j] <= '0;
      end
      phase     <= '0;
      active    <= '0;
      direction <= DRIVES'(1);
      enable_n  <= '1;
    end else if (push) begin
      elapsed     <= elapsed_next;
      half_period <= half_period_next;
      phase       <= phase_next;
      active      <= active_next;
      step_count  <= step_count_next;
      direction   <= direction_next;
      enable_n    <= enable_n_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      unique case (fill)
        2'd0: if (push) fill <= 2'd1;
        2'd1: if (push && !pop) fill <= 2'd2;
              else if (pop && !push) fill <= 2'd0;
        2'd2: if (pop) fill <= 2'd1;
        default: fill <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (fill)
      2'd0: if (push) slot0 <= res_new;
      2'd1: begin
        if (push && pop) slot0 <= res_new;
        else if (push) slot1 <= res_new;
      end
      2'd2: if (pop) slot0 <= slot1;
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/mstg_checker.sv =====
// ----------------------------------------------------------------------------
// mstg_checker
// Port-level checks on the stepper tone generator, bound to the top level.
// ----------------------------------------------------------------------------
module mstg_checker
  import mstg_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_stall,
  input logic res_valid,
  input logic res_stall,
  input res_t res
);

  // the buffer comes out of reset empty and open
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid && !cmd_stall)
    else $error("result buffer not empty after reset");

  // back-pressure only appears while a result is held
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> res_valid)
    else $error("command stalled with no result pending");

  // every transfer in leaves a result valid on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> res_valid)
    else $error("no result after command transfer");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

endmodule

bind multichannel_stepper_tone_generator mstg_checker u_mstg_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the eight-channel stepper tone generator. Drives
// tick, set and clear commands through the valid/stall command port and
// checks every pin snapshot against a cycle-free model of the channels. The
// run steps through a series of register settings, including the extremes.
// Idling on either side is random, and there is one long result hold-off that
// backs the block up.
// ----------------------------------------------------------------------------
module tb_top
  import mstg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PB = PERIOD_BITS_DEF;
  localparam int EB = (PB > IDLE_BITS) ? PB : IDLE_BITS;
  localparam longint unsigned PERIOD_MAX = (64'd1 << PB) - 1;
  localparam cmd_code_t CMD_UNUSED = cmd_code_t'(2'b11);
  localparam int RANDOM_BLOCKS = 8;
  localparam int BLOCK_ITEMS   = 250;

  localparam int unsigned SWEEP_ROWS [RANDOM_BLOCKS][DRIVES] = '{
    '{3, 5, 0, 255}, '{0, 1, 2, 3}, '{255, 255, 255, 255}, '{2, 0, 1, 4},
    '{1, 3, 0, 2}, '{7, 2, 255, 1}, '{0, 0, 0, 0}, '{4, 1, 3, 0}
  };
  localparam int unsigned IDLE_ROWS [RANDOM_BLOCKS] = '{6, 0, 262143, 1, 12, 40, 5, 2};
  localparam int unsigned PULSE_ROWS [RANDOM_BLOCKS] = '{1, 0, 1023, 2, 3, 1, 0, 2};

  // Channel model and pin scoreboard
  class tone_board;
    logic [SWEEP_BITS-1:0] sweep_len [DRIVES];
    logic [IDLE_BITS-1:0]  idle_limit;
    logic [PULSE_BITS-1:0] pulse_unit;
    logic [EB-1:0]         elapsed [CHANNELS];
    logic [PB-1:0]         half_period [CHANNELS];
    bit                    phase [CHANNELS];
    bit                    active [CHANNELS];
    logic [SWEEP_BITS-1:0] step_count [DRIVES];
    bit                    direction [DRIVES];
    bit                    enable_n [DRIVES];
    res_t                  pending_pins [$];
    int                    errors, checked, ticks, sets, clears, others;

    function new();
      sweep_len[0] = SWEEP0_RESET;
      for (int i = 1; i < DRIVES; i++) sweep_len[i] = SWEEP_RESET;
      idle_limit = IDLE_RESET;
      pulse_unit = PULSE_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        elapsed[i] = '0;
        half_period[i] = '0;
        phase[i] = 1'b0;
        active[i] = 1'b0;
      end
      for (int i = 0; i < DRIVES; i++) begin
        step_count[i] = '0;
        direction[i] = (i == 0);
        enable_n[i] = 1'b1;
      end
      errors = 0;
      checked = 0;
      ticks = 0;
      sets = 0;
      clears = 0;
      others = 0;
    endfunction

    function void write_register(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_SWEEP0: sweep_len[0] = data[SWEEP_BITS-1:0];
        CFG_SWEEP1: sweep_len[1] = data[SWEEP_BITS-1:0];
        CFG_SWEEP2: sweep_len[2] = data[SWEEP_BITS-1:0];
        CFG_SWEEP3: sweep_len[3] = data[SWEEP_BITS-1:0];
        CFG_IDLE:   idle_limit = data[IDLE_BITS-1:0];
        CFG_PULSE:  pulse_unit = data[PULSE_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [PB-1:0] clamp_period(longint unsigned v);
      return (v > PERIOD_MAX) ? PERIOD_MAX[PB-1:0] : v[PB-1:0];
    endfunction

    function void advance_channel(int i);
      if (elapsed[i] != '1) elapsed[i]++;
      if ((phase[i] || half_period[i] != 0) && elapsed[i] >= half_period[i]) begin
        if (!phase[i]) begin
          phase[i] = 1'b1;
        end else begin
          phase[i] = 1'b0;
          // falling phase completes a step on a drive, ends the pulse on a disk
          if (i < DRIVES) begin
            step_count[i] = step_count[i] + 1'b1;
            if (step_count[i] >= sweep_len[i]) begin
              direction[i] = !direction[i];
              step_count[i] = '0;
            end
          end else if (i >= DISK_FIRST) begin
            active[i] = 1'b0;
            half_period[i] = '0;
          end
        end
        elapsed[i] = '0;
      end else if (half_period[i] == 0 && active[i] && elapsed[i] >= idle_limit) begin
        if (i < DRIVES) enable_n[i] = 1'b1;
        active[i] = 1'b0;
      end
    endfunction

    function void load_channel(int ch, logic [PERIOD_IN_BITS-1:0] period,
                               logic [VELOCITY_BITS-1:0] vel);
      longint unsigned product;
      if (ch < DRIVES) begin
        half_period[ch] = clamp_period(ch == 0 ? 64'(period >> 2) : 64'(period >> 1));
        if (!active[ch]) begin
          elapsed[ch] = '0;
          enable_n[ch] = 1'b0;
          active[ch] = 1'b1;
        end
      end else if (ch < DISK_FIRST) begin
        active[ch] = 1'b1;
        half_period[ch] = clamp_period(64'(period >> 1));
      end else begin
        product = 64'(vel);
        product = product * 64'(pulse_unit);
        active[ch] = 1'b1;
        half_period[ch] = clamp_period(product);
      end
    endfunction

    function void drop_channel(int ch);
      if (ch < DRIVES) begin
        half_period[ch] = '0;
      end else if (ch < DISK_FIRST) begin
        active[ch] = 1'b0;
        half_period[ch] = '0;
      end
    endfunction

    function res_t current_pins();
      res_t r;
      for (int i = 0; i < DRIVES; i++) begin
        r.step_pins[i] = phase[i];
        r.direction_bits[i] = direction[i];
        r.enable_n_bits[i] = enable_n[i];
      end
      r.transformer_pin = phase[4];
      r.buzzer_pin = phase[5];
      r.disk_pins = {phase[7], phase[6]};
      return r;
    endfunction

    function void apply_command(cmd_t c);
      case (c.command)
        CMD_TICK: begin
          ticks++;
          for (int i = 0; i < CHANNELS; i++) advance_channel(i);
        end
        CMD_SET: begin
          sets++;
          load_channel(int'(c.channel), c.note_period, c.velocity);
        end
        CMD_CLEAR: begin
          clears++;
          drop_channel(int'(c.channel));
        end
        default: others++;
      endcase
      pending_pins.push_back(current_pins());
    endfunction

    function void compare_field(string field, logic [3:0] want, logic [3:0] got);
      if (want !== got) begin
        errors++;
        $display("%0d ns: %s expected %0h got %0h", $time, field, want, got);
      end
    endfunction

    function void check_pins(res_t got);
      res_t want;
      if (pending_pins.size() == 0) begin
        errors++;
        $display("%0d ns: result %h with no command outstanding", $time, got);
        return;
      end
      want = pending_pins.pop_front();
      checked++;
      compare_field("step_pins", want.step_pins, got.step_pins);
      compare_field("direction_bits", want.direction_bits, got.direction_bits);
      compare_field("enable_n_bits", want.enable_n_bits, got.enable_n_bits);
      compare_field("transformer_pin", 4'(want.transformer_pin), 4'(got.transformer_pin));
      compare_field("buzzer_pin", 4'(want.buzzer_pin), 4'(got.buzzer_pin));
      compare_field("disk_pins", 4'(want.disk_pins), 4'(got.disk_pins));
    endfunction

    function int pending();
      return pending_pins.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cmd_valid = 1'b0;
  logic                      cmd_stall;
  cmd_t                      cmd_word = '0;
  logic                      res_valid;
  logic                      res_stall = 1'b0;
  res_t                      res_word;
  logic                      cfg_wen = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      hold_off = 1'b0;

  tone_board tones;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int settings_applied = 0;

  multichannel_stepper_tone_generator dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res_word),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: check each transfer, then pick the next stall level
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) tones.check_pins(res_word);
    res_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    #3ms;
    $display("timeout with %0d results outstanding", tones.pending());
    $display("end of test: mismatches");
    $finish;
  end

  function automatic cmd_t make_cmd(cmd_code_t op, int unsigned ch, int unsigned period,
                                    int unsigned vel);
    cmd_t c;
    c.command = op;
    c.channel = ch[2:0];
    c.note_period = period[PERIOD_IN_BITS-1:0];
    c.velocity = vel[VELOCITY_BITS-1:0];
    return c;
  endfunction

  // Mostly short periods and small velocities so that tones complete
  function automatic cmd_t random_command();
    cmd_t c;
    int unsigned pick;
    c.channel = 3'($urandom_range(7));
    c.velocity = ($urandom_range(99) < 70) ? VELOCITY_BITS'($urandom_range(3))
                                           : VELOCITY_BITS'($urandom_range(127));
    pick = $urandom_range(99);
    if (pick < 70) c.note_period = PERIOD_IN_BITS'($urandom_range(24));
    else if (pick < 90) c.note_period = PERIOD_IN_BITS'($urandom_range(400));
    else c.note_period = PERIOD_IN_BITS'($urandom);
    pick = $urandom_range(99);
    if (pick < 62) c.command = CMD_TICK;
    else if (pick < 88) c.command = CMD_SET;
    else c.command = CMD_CLEAR;
    return c;
  endfunction

  // Hold valid high until the transfer; the next call may keep it high
  task automatic send_command(cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word <= c;
    do @(posedge clk); while (cmd_stall);
    tones.apply_command(c);
  endtask

  task automatic stop_commands();
    cmd_valid <= 1'b0;
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    tones.write_register(idx, data);
  endtask

  // Registers change only once every pending result has drained
  task automatic apply_settings(int unsigned s0, int unsigned s1, int unsigned s2,
                                int unsigned s3, int unsigned idle, int unsigned pulse);
    while (tones.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(CFG_SWEEP0, CFG_DATA_BITS'(s0));
    write_reg(CFG_SWEEP1, CFG_DATA_BITS'(s1));
    write_reg(CFG_SWEEP2, CFG_DATA_BITS'(s2));
    write_reg(CFG_SWEEP3, CFG_DATA_BITS'(s3));
    write_reg(CFG_IDLE, CFG_DATA_BITS'(idle));
    write_reg(CFG_PULSE, CFG_DATA_BITS'(pulse));
    cfg_wen <= 1'b0;
    settings_applied++;
  endtask

  task automatic hold_results(int cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  initial begin
    int blk;
    tones = new();
    send_idle_pct = 38;
    recv_idle_pct = 59;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: extreme periods and velocity, ignored clear, unused code
    send_command(make_cmd(CMD_SET, 0, 20'hFFFFF, 127));
    send_command(make_cmd(CMD_SET, 7, 0, 127));
    send_command(make_cmd(CMD_SET, 4, 20'hFFFFF, 0));
    send_command(make_cmd(CMD_SET, 5, 0, 0));
    send_command(make_cmd(CMD_SET, 3, 1, 0));
    send_command(make_cmd(CMD_CLEAR, 6, 0, 0));
    send_command(make_cmd(CMD_UNUSED, 2, 20'hFFFFF, 127));
    send_command(make_cmd(CMD_TICK, 7, 20'hFFFFF, 127));
    send_command(make_cmd(CMD_CLEAR, 4, 0, 0));
    send_command(make_cmd(CMD_CLEAR, 0, 0, 0));
    send_command(make_cmd(CMD_TICK, 0, 0, 0));
    stop_commands();

    // Zero sweep, short idle timeout, one-tick pulse unit
    apply_settings(0, 255, 1, 0, 3, 1);
    send_command(make_cmd(CMD_SET, 0, 4, 0));
    send_command(make_cmd(CMD_SET, 1, 2, 0));
    send_command(make_cmd(CMD_SET, 6, 0, 2));
    send_command(make_cmd(CMD_SET, 2, 0, 0));
    repeat (8) send_command(make_cmd(CMD_TICK, $urandom_range(7), $urandom, $urandom));
    send_command(make_cmd(CMD_CLEAR, 1, 0, 0));
    send_command(make_cmd(CMD_TICK, 0, 0, 0));

    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      stop_commands();
      apply_settings(SWEEP_ROWS[blk][0], SWEEP_ROWS[blk][1], SWEEP_ROWS[blk][2],
                     SWEEP_ROWS[blk][3], IDLE_ROWS[blk], PULSE_ROWS[blk]);
      if (blk < 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 59;
      end else if (blk < 6) begin
        send_idle_pct = 59;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // back the block up with a long result hold-off while commands keep coming
      if (blk == 6) begin
        fork
          hold_results(400);
        join_none
      end
      repeat (BLOCK_ITEMS) send_command(random_command());
    end
    stop_commands();

    while (tones.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d pin snapshots checked from %0d ticks, %0d sets, %0d clears, %0d unused",
             tones.checked, tones.ticks, tones.sets, tones.clears, tones.others);
    $display("%0d register settings applied, %0d mismatches", settings_applied,
             tones.errors);
    if (tones.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
